// ===== rtl/core/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants and types for the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int unsigned MAX_INDEX   = 63;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = 16;

  // highest index that is actually kept in the store
  localparam int unsigned STORE_LIM =
    (MAX_INDEX > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : MAX_INDEX;

  localparam logic [7:0]         DELIM     = 8'h24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] LIM_CNT   = COUNT_W'(STORE_LIM);
  localparam logic [ADDR_W-1:0]  LIM_ADDR  = ADDR_W'(STORE_LIM);

  // controller to datapath
  typedef struct packed {
    logic take;     // input transaction accepted this cycle
    logic rd;       // read the store at the drain index
    logic advance;  // step the drain index
  } dfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;     // accepted byte closes a good frame
    logic last;     // drain index is on the final byte
  } dfr_status_t;

endpackage

// ===== rtl/core/dfr_ram.sv =====
// ----------------------------------------------------------------------------
// dfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/dfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfr_ctrl
// Controller: takes input bytes and sequences the drain of a closed frame.
// ----------------------------------------------------------------------------
module dfr_ctrl import dfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dfr_cmd_t    cmd_o,
  input  dfr_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   take;

  assign take = in_valid_i & in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take && status_i.emit) begin
            state_q    <= ST_READ;
            in_ready_q <= 1'b0;
          end
        end
        ST_READ: begin
          state_q     <= ST_SHOW;
          out_valid_q <= 1'b1;
        end
        ST_SHOW: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (status_i.last) begin
              state_q    <= ST_IDLE;
              in_ready_q <= 1'b1;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.take    = take;
  assign cmd_o.rd      = (state_q == ST_READ);
  assign cmd_o.advance = (state_q == ST_SHOW) & out_ready_i & ~status_i.last;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/dfr_datapath.sv =====
// ----------------------------------------------------------------------------
// dfr_datapath
// Datapath: receive mode, error mark, byte counter, payload store, drain.
// ----------------------------------------------------------------------------
module dfr_datapath import dfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         rx_byte_i,
  input  logic               rx_error_i,
  input  dfr_cmd_t           cmd_i,
  output dfr_status_t        status_o,
  output logic [7:0]         frame_byte_o,
  output logic               frame_last_o,
  output logic [COUNT_W-1:0] frame_count_o,
  output logic               truncated_o
);

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_START   = 2'd1,
    MODE_PAYLOAD = 2'd2
  } rx_mode_e;

  rx_mode_e           mode_q, mode_d;
  logic               err_seen_q, err_seen_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] count_inc;

  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0]  last_q, last_d;
  logic [COUNT_W-1:0] snap_count_q, snap_count_d;
  logic               snap_trunc_q, snap_trunc_d;

  logic               is_delim;
  logic               emit;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         rd_data;

  assign is_delim  = (rx_byte_i == DELIM);
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
  assign emit      = cmd_i.take & ~rx_error_i & (mode_q == MODE_PAYLOAD)
                   & is_delim & ~err_seen_q;

  always_comb begin
    mode_d       = mode_q;
    err_seen_d   = err_seen_q;
    count_d      = count_q;
    wr_en        = 1'b0;
    wr_addr      = ADDR_W'(1);
    idx_d        = idx_q;
    last_d       = last_q;
    snap_count_d = snap_count_q;
    snap_trunc_d = snap_trunc_q;

    if (cmd_i.advance) begin
      idx_d = idx_q + ADDR_W'(1);
    end

    if (cmd_i.take) begin
      if (rx_error_i) begin
        err_seen_d = 1'b1;
      end else begin
        case (mode_q)
          MODE_START: begin
            if (is_delim) begin
              count_d    = '0;
              err_seen_d = 1'b0;
            end else begin
              mode_d  = MODE_PAYLOAD;
              count_d = COUNT_W'(1);
              wr_en   = 1'b1;
              wr_addr = ADDR_W'(1);
            end
          end
          MODE_PAYLOAD: begin
            if (is_delim) begin
              if (emit) begin
                idx_d        = '0;
                snap_count_d = count_q;
                snap_trunc_d = (count_q > LIM_CNT);
                last_d       = (count_q > LIM_CNT) ? LIM_ADDR : count_q[ADDR_W-1:0];
              end
              mode_d     = MODE_START;
              count_d    = '0;
              err_seen_d = 1'b0;
            end else begin
              count_d = count_inc;
              wr_en   = (count_inc <= LIM_CNT);
              wr_addr = count_inc[ADDR_W-1:0];
            end
          end
          default: begin
            // hunting, and the unused mode code
            if (is_delim) begin
              mode_d     = MODE_START;
              count_d    = '0;
              err_seen_d = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HUNT;
      err_seen_q <= 1'b0;
      count_q    <= '0;
    end else begin
      mode_q     <= mode_d;
      err_seen_q <= err_seen_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    last_q       <= last_d;
    snap_count_q <= snap_count_d;
    snap_trunc_q <= snap_trunc_d;
  end

  dfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (cmd_i.rd),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // drain index 0 always shows the leading delimiter
  assign frame_byte_o  = (idx_q == '0) ? DELIM : rd_data;
  assign frame_last_o  = (idx_q == last_q);
  assign frame_count_o = snap_count_q;
  assign truncated_o   = snap_trunc_q;

  assign status_o.emit = emit;
  assign status_o.last = (idx_q == last_q);

endmodule

// ===== rtl/core/delimited_frame_receiver_top.sv =====
// A closing '$' moves the controller to its read state; the first frame byte is then shown
// from its show state. Throughput: one input byte per cycle while no frame drains; each
// drained result passes through a store read state and a show state that waits for the sink.
// Input is held off while a frame drains.
// Reset clears mode, error mark and counter; the payload store is not cleared.
// ----------------------------------------------------------------------------
// delimited_frame_receiver_top
// Receiver for '$'-delimited serial frames with line-error discard.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_top import dfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               rx_error_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_byte_o,
  output logic               frame_last_o,
  output logic [COUNT_W-1:0] frame_count_o,
  output logic               truncated_o
);

  dfr_cmd_t    cmd;
  dfr_status_t status;

  dfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dfr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .rx_error_i    (rx_error_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .frame_byte_o  (frame_byte_o),
    .frame_last_o  (frame_last_o),
    .frame_count_o (frame_count_o),
    .truncated_o   (truncated_o)
  );

endmodule
